// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the trie word store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising edge of the given clock, off while reset is low.
`define TWS_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// Checks a property on clk, off while rst_n is low.
`define TWS_ASSERT(lbl, prop, msg) \
  `TWS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== hw/rtl/tws_pkg.sv =====
// Package with the constants, codes and control types of the trie word store.
package tws_pkg;

  localparam int NODE_COUNT    = 256;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = 8;
  localparam int USED_W        = NODE_W + 1;
  localparam int LETTER_W      = 5;
  localparam int CMD_W         = 2;
  localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_EXACT  = 2'd1,
    CMD_PREFIX = 2'd2
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic step;
    logic mark;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last;
  } dp_status_t;

endpackage

// ===== hw/rtl/tws_ctrl.sv =====
// Controller state machine that sequences clearing, letter steps and results.
module tws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output tws_pkg::dp_cmd_t    cmd,
  input  tws_pkg::dp_status_t status
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOK   = 5'b00100,
    S_MARK   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.step  = 1'b1;
        state_nxt = status.last ? S_MARK : S_IDLE;
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/tws_datapath.sv =====
// Datapath with the child pointer and end mark memories, the walk and the result.
module tws_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tws_pkg::dp_cmd_t              cmd,
  output tws_pkg::dp_status_t           status,
  input  logic [tws_pkg::CMD_W-1:0]     in_command,
  input  logic [tws_pkg::LETTER_W-1:0]  in_letter,
  input  logic                          in_last_letter,
  output logic                          out_found,
  output logic                          out_out_of_nodes
);

  logic [tws_pkg::NODE_W-1:0] child_mem [tws_pkg::SLOT_COUNT];
  logic                       em_mem    [tws_pkg::NODE_COUNT];

  logic [tws_pkg::SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [tws_pkg::USED_W-1:0] nodes_used_r, nodes_used_nxt;
  logic [tws_pkg::NODE_W-1:0] walk_node_r, walk_node_nxt;
  logic                       walk_missing_r, walk_missing_nxt;
  logic                       walk_overflow_r, walk_overflow_nxt;

  logic [tws_pkg::CMD_W-1:0]  cmd_r;
  logic                       letter_bad_r;
  logic                       last_r;
  logic [tws_pkg::SLOT_W-1:0] slot_r;
  logic [tws_pkg::NODE_W-1:0] child_rd_r;
  logic                       em_rd_r;
  logic                       found_r, found_nxt;
  logic                       oon_r, oon_nxt;

  logic                       letter_bad;
  logic [tws_pkg::SLOT_W-1:0] slot_calc;
  logic [tws_pkg::SLOT_W-1:0] rd_addr;
  logic                       cmd_known;
  logic                       pool_full;
  logic                       child_we;
  logic                       em_we;
  logic                       clr_in_em;

  assign letter_bad = (in_letter >= tws_pkg::LETTER_W'(tws_pkg::ALPHABET_SIZE));
  assign slot_calc  = tws_pkg::SLOT_W'(walk_node_r) * tws_pkg::SLOT_W'(tws_pkg::ALPHABET_SIZE)
                    + tws_pkg::SLOT_W'(in_letter);
  assign rd_addr    = letter_bad ? '0 : slot_calc;
  assign cmd_known  = (cmd_r == tws_pkg::CMD_INSERT) || (cmd_r == tws_pkg::CMD_EXACT) ||
                      (cmd_r == tws_pkg::CMD_PREFIX);
  assign pool_full  = (nodes_used_r == tws_pkg::USED_W'(tws_pkg::NODE_COUNT));
  assign clr_in_em  = (clr_addr_r < tws_pkg::SLOT_W'(tws_pkg::NODE_COUNT));
  assign em_we      = cmd.mark && (cmd_r == tws_pkg::CMD_INSERT) && !walk_missing_r;

  assign status.clear_done = (clr_addr_r == tws_pkg::SLOT_W'(tws_pkg::SLOT_COUNT - 1));
  assign status.last       = last_r;

  always_comb begin
    clr_addr_nxt      = clr_addr_r;
    nodes_used_nxt    = nodes_used_r;
    walk_node_nxt     = walk_node_r;
    walk_missing_nxt  = walk_missing_r;
    walk_overflow_nxt = walk_overflow_r;
    found_nxt         = found_r;
    oon_nxt           = oon_r;
    child_we          = 1'b0;
    if (cmd.clear && !status.clear_done) begin
      clr_addr_nxt = clr_addr_r + tws_pkg::SLOT_W'(1);
    end
    if (cmd.step && !walk_missing_r && cmd_known) begin
      if (letter_bad_r) begin
        walk_missing_nxt = 1'b1;
      end else if (child_rd_r != '0) begin
        walk_node_nxt = child_rd_r;
      end else if (cmd_r != tws_pkg::CMD_INSERT) begin
        walk_missing_nxt = 1'b1;
      end else if (pool_full) begin
        walk_missing_nxt  = 1'b1;
        walk_overflow_nxt = 1'b1;
      end else begin
        child_we       = 1'b1;
        walk_node_nxt  = nodes_used_r[tws_pkg::NODE_W-1:0];
        nodes_used_nxt = nodes_used_r + tws_pkg::USED_W'(1);
      end
    end
    if (cmd.finish) begin
      found_nxt = 1'b0;
      oon_nxt   = 1'b0;
      case (cmd_r)
        tws_pkg::CMD_INSERT: oon_nxt   = walk_overflow_r;
        tws_pkg::CMD_EXACT:  found_nxt = !walk_missing_r && em_rd_r;
        tws_pkg::CMD_PREFIX: found_nxt = !walk_missing_r;
        default:             found_nxt = 1'b0;
      endcase
      walk_node_nxt     = '0;
      walk_missing_nxt  = 1'b0;
      walk_overflow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r      <= '0;
      nodes_used_r    <= tws_pkg::USED_W'(1);
      walk_node_r     <= '0;
      walk_missing_r  <= 1'b0;
      walk_overflow_r <= 1'b0;
    end else begin
      clr_addr_r      <= clr_addr_nxt;
      nodes_used_r    <= nodes_used_nxt;
      walk_node_r     <= walk_node_nxt;
      walk_missing_r  <= walk_missing_nxt;
      walk_overflow_r <= walk_overflow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r        <= in_command;
      letter_bad_r <= letter_bad;
      last_r       <= in_last_letter;
      slot_r       <= rd_addr;
    end
    found_r <= found_nxt;
    oon_r   <= oon_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      child_mem[clr_addr_r] <= '0;
    end else if (child_we) begin
      child_mem[slot_r] <= nodes_used_r[tws_pkg::NODE_W-1:0];
    end
    if (cmd.start) begin
      child_rd_r <= child_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && clr_in_em) begin
      em_mem[clr_addr_r[tws_pkg::NODE_W-1:0]] <= 1'b0;
    end else if (em_we) begin
      em_mem[walk_node_r] <= 1'b1;
    end
    if (cmd.mark) begin
      em_rd_r <= em_mem[walk_node_r];
    end
  end

  assign out_found        = found_r;
  assign out_out_of_nodes = oon_r;

endmodule

// ===== hw/rtl/trie_word_store_core.sv =====
// Top level of the trie word store: a lower-case word trie in a 256-node pool.
//
// Words arrive one letter per input item (command, letter, last-letter mark).
// Commands are insert, exact search and prefix search. Every word ends with
// one result item on the output channel: found, and out_of_nodes for inserts.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// A letter that is not the last one takes a fetch step that reads the child
// pointer memory and a step that follows or allocates the child. For a last
// letter the end mark memory is then read or written, and the result is
// loaded into the output register once it is free or its result is taken.
// Each letter's lookup address needs the child pointer read for the letter
// before it, so in_stall holds off the next letter until this one is done.
// After reset the block clears the child pointer and end mark memories and
// holds in_stall high until the clearing is done.
// While the receiver stalls, the result waits in the output register; the
// block still takes further letters and holds only when the next result
// is ready to be loaded.
`include "assert_macros.svh"

module trie_word_store_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tws_pkg::CMD_W-1:0]     in_command,
  input  logic [tws_pkg::LETTER_W-1:0]  in_letter,
  input  logic                          in_last_letter,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic                          out_out_of_nodes
);

  tws_pkg::dp_cmd_t    dp_cmd;
  tws_pkg::dp_status_t dp_status;

  tws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

  tws_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (dp_cmd),
    .status           (dp_status),
    .in_command       (in_command),
    .in_letter        (in_letter),
    .in_last_letter   (in_last_letter),
    .out_found        (out_found),
    .out_out_of_nodes (out_out_of_nodes)
  );

  `TWS_ASSERT(a_step_after_start, dp_cmd.step |-> $past(dp_cmd.start), "step without a fetch")
  `TWS_ASSERT(a_result_from_finish, $rose(out_valid) |-> $past(dp_cmd.finish), "result not loaded")
  `TWS_ASSERT(a_no_overwrite, dp_cmd.finish |-> (!out_valid || !out_stall), "pending result lost")

endmodule

// ===== tb/tb_trie_word_store_core.sv =====
// Self-checking testbench for trie_word_store_core: random and directed words checked by a trie predictor.
module tb_trie_word_store_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tws_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_WORD = 8;

  typedef struct packed {
    logic found;
    logic out_of_nodes;
  } answer_t;

  typedef struct packed {
    logic [3:0] len;
    logic [MAX_WORD-1:0][tws_pkg::LETTER_W-1:0] ch;
  } word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [tws_pkg::CMD_W-1:0] in_command;
  logic [tws_pkg::LETTER_W-1:0] in_letter;
  logic in_last_letter;
  logic out_valid;
  logic out_stall;
  logic out_found;
  logic out_out_of_nodes;

  logic [tws_pkg::NODE_W-1:0] trie_child [tws_pkg::SLOT_COUNT];
  bit word_end [tws_pkg::NODE_COUNT];
  int pool_used;
  logic [tws_pkg::NODE_W-1:0] walk_at;
  bit walk_lost;
  bit walk_full;

  answer_t pending_answers[$];
  answer_t want;
  word_t known_words[$];
  bit steady;
  int errors;
  int letters_sent;
  int words_sent;
  int answers_seen;
  int found_seen;
  int full_seen;

  trie_word_store_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_letter(in_letter),
    .in_last_letter(in_last_letter),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_out_of_nodes(out_out_of_nodes)
  );

  always #10 clk = ~clk;

  function automatic int idle_gap();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void take_letter(logic [tws_pkg::CMD_W-1:0] cmd,
                                      logic [tws_pkg::LETTER_W-1:0] letter, logic last);
    int slot;
    logic [tws_pkg::NODE_W-1:0] next;
    answer_t ans;
    if (!walk_lost && cmd != CMD_UNUSED) begin
      if (letter >= tws_pkg::ALPHABET_SIZE) begin
        walk_lost = 1'b1;
      end else begin
        slot = int'(walk_at) * tws_pkg::ALPHABET_SIZE + int'(letter);
        next = trie_child[slot];
        if (next == '0 && cmd != tws_pkg::CMD_INSERT) begin
          walk_lost = 1'b1;
        end else if (next == '0 && pool_used >= tws_pkg::NODE_COUNT) begin
          walk_lost = 1'b1;
          walk_full = 1'b1;
        end else begin
          if (next == '0) begin
            next = pool_used[tws_pkg::NODE_W-1:0];
            pool_used++;
            trie_child[slot] = next;
          end
          walk_at = next;
        end
      end
    end
    if (last) begin
      ans = '0;
      case (cmd)
        tws_pkg::CMD_INSERT: begin
          if (!walk_lost) word_end[walk_at] = 1'b1;
          ans.out_of_nodes = walk_full;
        end
        tws_pkg::CMD_EXACT: ans.found = !walk_lost && word_end[walk_at];
        tws_pkg::CMD_PREFIX: ans.found = !walk_lost;
        default: ;
      endcase
      pending_answers.push_back(ans);
      walk_at = '0;
      walk_lost = 1'b0;
      walk_full = 1'b0;
    end
  endfunction

  function automatic word_t random_word(int top_letter, int min_len, int max_len);
    word_t w;
    w = '0;
    w.len = 4'($urandom_range(min_len, max_len));
    for (int i = 0; i < int'(w.len); i++)
      w.ch[i] = tws_pkg::LETTER_W'($urandom_range(0, top_letter));
    return w;
  endfunction

  function automatic word_t known_or_random(int top_letter);
    if (known_words.size() == 0) return random_word(top_letter, 1, 4);
    return known_words[$urandom_range(0, known_words.size() - 1)];
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_letter(logic [tws_pkg::CMD_W-1:0] cmd,
                             logic [tws_pkg::LETTER_W-1:0] letter, logic last);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_letter <= letter;
    in_last_letter <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_letter(cmd, letter, last);
    letters_sent++;
    if (last) words_sent++;
  endtask

  task automatic send_word(logic [tws_pkg::CMD_W-1:0] cmd, word_t w);
    if ($urandom_range(0, 15) == 0) steady = !steady;
    for (int i = 0; i < int'(w.len); i++) send_letter(cmd, w.ch[i], i == int'(w.len) - 1);
  endtask

  task automatic test_directed();
    send_letter(tws_pkg::CMD_INSERT, 5'd0, 1'b1);
    send_letter(tws_pkg::CMD_INSERT, 5'd25, 1'b0);
    send_letter(tws_pkg::CMD_INSERT, 5'd25, 1'b1);
    send_letter(tws_pkg::CMD_EXACT, 5'd0, 1'b1);
    send_letter(tws_pkg::CMD_EXACT, 5'd25, 1'b1);
    send_letter(tws_pkg::CMD_PREFIX, 5'd25, 1'b1);
    send_letter(tws_pkg::CMD_EXACT, 5'd25, 1'b0);
    send_letter(tws_pkg::CMD_EXACT, 5'd25, 1'b1);
    send_letter(tws_pkg::CMD_PREFIX, 5'd1, 1'b1);
    send_letter(tws_pkg::CMD_INSERT, 5'd31, 1'b1);
    send_letter(tws_pkg::CMD_INSERT, 5'd0, 1'b0);
    send_letter(tws_pkg::CMD_INSERT, 5'd30, 1'b1);
    send_letter(CMD_UNUSED, 5'd0, 1'b0);
    send_letter(CMD_UNUSED, 5'd17, 1'b1);
    send_letter(tws_pkg::CMD_INSERT, 5'd2, 1'b0);
    send_letter(tws_pkg::CMD_EXACT, 5'd3, 1'b1);
    send_letter(tws_pkg::CMD_PREFIX, 5'd2, 1'b1);
    send_letter(tws_pkg::CMD_PREFIX, 5'd0, 1'b0);
    send_letter(tws_pkg::CMD_INSERT, 5'd1, 1'b1);
    send_letter(tws_pkg::CMD_EXACT, 5'd0, 1'b0);
    send_letter(tws_pkg::CMD_EXACT, 5'd1, 1'b1);
  endtask

  task automatic test_shared_words(int stop_at);
    word_t w;
    int pick;
    while (letters_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        w = random_word(2, 1, 4);
        known_words.push_back(w);
        send_word(tws_pkg::CMD_INSERT, w);
      end else if (pick < 7) begin
        send_word(tws_pkg::CMD_EXACT, known_or_random(2));
      end else if (pick < 9) begin
        w = known_or_random(2);
        w.len = 4'($urandom_range(1, w.len));
        send_word(tws_pkg::CMD_PREFIX, w);
      end else begin
        send_word(tws_pkg::CMD_EXACT, random_word(3, 1, 5));
      end
    end
  endtask

  task automatic test_pool_exhaustion(int stop_at);
    word_t w;
    int pick;
    while (letters_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w = random_word(25, 4, MAX_WORD);
        known_words.push_back(w);
        send_word(tws_pkg::CMD_INSERT, w);
      end else if (pick < 9) begin
        send_word(tws_pkg::CMD_EXACT, known_or_random(25));
      end else begin
        w = known_or_random(25);
        w.len = 4'($urandom_range(1, w.len));
        send_word(tws_pkg::CMD_PREFIX, w);
      end
    end
  endtask

  task automatic test_noise(int stop_at);
    word_t w;
    logic [tws_pkg::CMD_W-1:0] base;
    logic [tws_pkg::CMD_W-1:0] cmd;
    logic [tws_pkg::LETTER_W-1:0] letter;
    while (letters_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      w = ($urandom_range(0, 1) == 0) ? known_or_random(25) : random_word(25, 1, 6);
      base = tws_pkg::CMD_W'($urandom_range(0, 2));
      for (int i = 0; i < int'(w.len); i++) begin
        cmd = ($urandom_range(0, 3) == 0) ? tws_pkg::CMD_W'($urandom_range(0, 3)) : base;
        letter = ($urandom_range(0, 4) == 0) ? tws_pkg::LETTER_W'($urandom_range(26, 31))
                                             : w.ch[i];
        send_letter(cmd, letter, i == int'(w.len) - 1);
      end
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin : receiver
      int gap;
      @(negedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_error("result arrived with no word pending");
      end else begin
        want = pending_answers.pop_front();
        answers_seen++;
        if (out_found) found_seen++;
        if (out_out_of_nodes) full_seen++;
        if (out_found !== want.found)
          report_error($sformatf("result %0d: found %b, expected %b",
                                 answers_seen, out_found, want.found));
        if (out_out_of_nodes !== want.out_of_nodes)
          report_error($sformatf("result %0d: out_of_nodes %b, expected %b",
                                 answers_seen, out_out_of_nodes, want.out_of_nodes));
      end
    end
  end

  initial begin
    #5ms;
    $display("tb_trie_word_store_core failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = tws_pkg::CMD_INSERT;
    in_letter = '0;
    in_last_letter = 1'b0;
    steady = 1'b0;
    for (int i = 0; i < tws_pkg::SLOT_COUNT; i++) trie_child[i] = '0;
    for (int i = 0; i < tws_pkg::NODE_COUNT; i++) word_end[i] = 1'b0;
    pool_used = 1;
    walk_at = '0;
    walk_lost = 1'b0;
    walk_full = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_shared_words(500);
    test_pool_exhaustion(1050);
    test_noise(1280);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d letters in %0d words; %0d nodes of %0d in use.",
             letters_sent, words_sent, pool_used, tws_pkg::NODE_COUNT);
    $display("Checked %0d results: %0d found, %0d reporting a full pool.",
             answers_seen, found_seen, full_seen);
    if (errors == 0) begin
      $display("tb_trie_word_store_core passed");
    end else begin
      $display("tb_trie_word_store_core failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ctrl.sv
hw/rtl/tws_datapath.sv
hw/rtl/trie_word_store_core.sv
tb/tb_trie_word_store_core.sv
